>>> rtl/delimited_token_lexer_top_macros.svh
// assertion macros for the delimited token lexer
// used by modules that carry concurrent checks; needs clk_i and rst_ni in scope
`ifndef DELIMITED_TOKEN_LEXER_TOP_MACROS_SVH
`define DELIMITED_TOKEN_LEXER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define DTL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define DTL_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define DTL_ASSERT(lbl, prop, msg)

`define DTL_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

>>> rtl/dtl_pkg.sv
// shared types, codes and character constants of the delimited token lexer
// no dependencies
package dtl_pkg;

  localparam int unsigned MaxIdentCharsDefault = 8;
  localparam int unsigned QueueDepthDefault    = 4;
  localparam int unsigned IdentBytes           = 8;
  localparam int unsigned Radix                = 10;

  localparam logic [7:0]  CharNul   = 8'h00;
  localparam logic [7:0]  CharNl    = 8'h0A;
  localparam logic [7:0]  CharSpace = 8'h20;
  localparam logic [7:0]  CharPlus  = 8'h2B;
  localparam logic [7:0]  CharZero  = 8'h30;
  localparam logic [7:0]  CharNine  = 8'h39;
  localparam logic [7:0]  CharEq    = 8'h3D;
  localparam logic [7:0]  CharUpA   = 8'h41;
  localparam logic [7:0]  CharUpZ   = 8'h5A;
  localparam logic [7:0]  CharUnder = 8'h5F;
  localparam logic [7:0]  CharLoA   = 8'h61;
  localparam logic [7:0]  CharLoZ   = 8'h7A;
  localparam logic [63:0] EchoWord  = 64'h0000_0000_6F68_6365;

  typedef enum logic [2:0] {
    KindNumber = 3'd0,
    KindIdent  = 3'd1,
    KindEcho   = 3'd2,
    KindPlus   = 3'd3,
    KindEquals = 3'd4,
    KindEndOk  = 3'd5,
    KindError  = 3'd6
  } token_kind_e;

  typedef enum logic [2:0] {
    ErrNone      = 3'd0,
    ErrBadChar   = 3'd1,
    ErrMalformed = 3'd2,
    ErrNoTokens  = 3'd3,
    ErrTooLong   = 3'd4
  } error_code_e;

  typedef struct packed {
    token_kind_e token_kind;
    error_code_e error_code;
    logic [31:0] number_value;
    logic [63:0] ident_text;
    logic [3:0]  ident_length;
    logic        last_of_run;
  } dtl_result_t;

  // one queue entry: results caused by one byte
  typedef struct packed {
    logic        has_tok;
    dtl_result_t tok;
    logic        has_end;
    token_kind_e end_kind;
    error_code_e end_code;
  } dtl_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dtl_q_stat_t;

endpackage

>>> rtl/dtl_if.sv
// valid/ready channel interfaces for text bytes and tokens
// depends on dtl_pkg
interface dtl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface dtl_token_if;
  import dtl_pkg::*;
  token_kind_e token_kind;
  error_code_e error_code;
  logic        valid;
  logic        ready;
  logic [31:0] number_value;
  logic [63:0] ident_text;
  logic [3:0]  ident_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output error_code, output number_value,
                  output ident_text, output ident_length, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input error_code, input number_value,
                input ident_text, input ident_length, input last_of_run, output ready);
endinterface

>>> rtl/dtl_front.sv
// front end: accepts text bytes, builds the lexeme and classifies it
// depends on dtl_pkg and dtl_if; pushes per-byte entries into the queue
module dtl_front #(
  parameter int unsigned MaxIdentChars = dtl_pkg::MaxIdentCharsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  dtl_byte_if.sink            in_i,
  input  dtl_pkg::dtl_q_stat_t q_stat_i,
  output logic                push_o,
  output dtl_pkg::dtl_entry_t push_entry_o
);
  import dtl_pkg::*;

  localparam logic [3:0] MaxLen = 4'(MaxIdentChars);

  logic [3:0]  len_q, len_d;
  logic        all_dig_q, all_dig_d;
  logic        id_ok_q, id_ok_d;
  logic [7:0]  first_q, first_d;
  logic [31:0] acc_q, acc_d;
  logic [63:0] chars_q, chars_d;
  logic        any_q, any_d;
  logic        hold_q, hold_d;

  logic        accept;
  logic [7:0]  b;
  logic        is_nul, is_delim, is_dig, is_alp, is_sym;
  dtl_result_t tok;
  logic        tok_ok;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.text_byte;

  assign is_nul   = (b == CharNul);
  assign is_delim = (b == CharSpace) || (b == CharNl);
  assign is_dig   = (b >= CharZero) && (b <= CharNine);
  assign is_alp   = ((b >= CharLoA) && (b <= CharLoZ)) || ((b >= CharUpA) && (b <= CharUpZ)) ||
                    (b == CharUnder);
  assign is_sym   = (b == CharPlus) || (b == CharEq);

  // classify the pending lexeme
  always_comb begin
    tok              = '0;
    tok.token_kind   = KindError;
    tok.error_code   = ErrNone;
    tok_ok           = 1'b1;
    if (all_dig_q) begin
      tok.token_kind   = KindNumber;
      tok.number_value = acc_q;
    end else if (id_ok_q) begin
      if (len_q > MaxLen) begin
        tok.token_kind   = KindIdent;
        tok.error_code   = ErrTooLong;
        tok.ident_text   = chars_q;
        tok.ident_length = MaxLen;
      end else if ((len_q == 4'd4) && (chars_q == EchoWord)) begin
        tok.token_kind = KindEcho;
      end else begin
        tok.token_kind   = KindIdent;
        tok.ident_text   = chars_q;
        tok.ident_length = len_q;
      end
    end else if ((len_q == 4'd1) && (first_q == CharPlus)) begin
      tok.token_kind = KindPlus;
    end else if ((len_q == 4'd1) && (first_q == CharEq)) begin
      tok.token_kind = KindEquals;
    end else begin
      tok.token_kind = KindError;
      tok.error_code = ErrMalformed;
      tok_ok         = 1'b0;
    end
    tok.last_of_run = !is_nul;
  end

  always_comb begin
    len_d        = len_q;
    all_dig_d    = all_dig_q;
    id_ok_d      = id_ok_q;
    first_d      = first_q;
    acc_d        = acc_q;
    chars_d      = chars_q;
    any_d        = any_q;
    hold_d       = hold_q;
    push_o       = 1'b0;
    push_entry_o = '0;
    push_entry_o.tok      = tok;
    push_entry_o.end_kind = KindEndOk;
    push_entry_o.end_code = ErrNone;

    if (accept) begin
      if (is_nul) begin
        push_o               = 1'b1;
        push_entry_o.has_tok = !hold_q && (len_q != 4'd0);
        push_entry_o.has_end = 1'b1;
        if (!(any_q || (push_entry_o.has_tok && tok_ok))) begin
          push_entry_o.end_kind = KindError;
          push_entry_o.end_code = ErrNoTokens;
        end
        len_d     = '0;
        all_dig_d = 1'b1;
        id_ok_d   = 1'b1;
        first_d   = '0;
        acc_d     = '0;
        chars_d   = '0;
        any_d     = 1'b0;
        hold_d    = 1'b0;
      end else if (hold_q) begin
        hold_d = 1'b1;
      end else if (is_delim) begin
        if (len_q != 4'd0) begin
          push_o               = 1'b1;
          push_entry_o.has_tok = 1'b1;
          any_d     = any_q || tok_ok;
          hold_d    = !tok_ok;
          len_d     = '0;
          all_dig_d = 1'b1;
          id_ok_d   = 1'b1;
          first_d   = '0;
          acc_d     = '0;
          chars_d   = '0;
        end
      end else if (!is_dig && !is_alp && !is_sym) begin
        push_o                      = 1'b1;
        push_entry_o.has_tok        = 1'b1;
        push_entry_o.tok            = '0;
        push_entry_o.tok.token_kind = KindError;
        push_entry_o.tok.error_code = ErrBadChar;
        push_entry_o.tok.last_of_run = 1'b1;
        hold_d    = 1'b1;
        len_d     = '0;
        all_dig_d = 1'b1;
        id_ok_d   = 1'b1;
        first_d   = '0;
        acc_d     = '0;
        chars_d   = '0;
      end else begin
        if (len_q == 4'd0) begin
          first_d = b;
          id_ok_d = is_alp;
        end else begin
          id_ok_d = id_ok_q && (is_alp || is_dig);
        end
        all_dig_d = all_dig_q && is_dig;
        if (is_dig) begin
          acc_d = acc_q * 32'(Radix) + {24'd0, b - CharZero};
        end
        for (int i = 0; i < IdentBytes; i++) begin
          if ((4'(i) == len_q) && (len_q < MaxLen)) begin
            chars_d[i*8 +: 8] = b;
          end
        end
        if (len_q != 4'd15) begin
          len_d = len_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      all_dig_q <= 1'b1;
      id_ok_q   <= 1'b1;
      first_q   <= '0;
      acc_q     <= '0;
      chars_q   <= '0;
      any_q     <= 1'b0;
      hold_q    <= 1'b0;
    end else begin
      len_q     <= len_d;
      all_dig_q <= all_dig_d;
      id_ok_q   <= id_ok_d;
      first_q   <= first_d;
      acc_q     <= acc_d;
      chars_q   <= chars_d;
      any_q     <= any_d;
      hold_q    <= hold_d;
    end
  end

endmodule

>>> rtl/dtl_queue.sv
// short queue of per-byte entries between front and back end
// depends on dtl_pkg and the assertion macro header
module dtl_queue #(
  parameter int unsigned Depth = dtl_pkg::QueueDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dtl_pkg::dtl_entry_t  push_entry_i,
  input  logic                 pop_i,
  output dtl_pkg::dtl_entry_t  head_o,
  output dtl_pkg::dtl_q_stat_t stat_o
);
  import dtl_pkg::*;

`include "delimited_token_lexer_top_macros.svh"

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  dtl_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  `DTL_ASSERT(a_push_has_room, push_i |-> (cnt_q != FullCnt), "push into full queue")
  `DTL_ASSERT(a_pop_has_data, pop_i |-> (cnt_q != '0), "pop from empty queue")
  `DTL_ASSERT_NEVER(a_cnt_bound, cnt_q > FullCnt, "queue count beyond depth")

endmodule

>>> rtl/dtl_back.sv
// back end: unpacks queue entries into result beats on the output register
// depends on dtl_pkg and dtl_if
module dtl_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dtl_pkg::dtl_entry_t  head_i,
  input  dtl_pkg::dtl_q_stat_t q_stat_i,
  output logic                 pop_o,
  dtl_token_if.source          out_o
);
  import dtl_pkg::*;

  logic        out_vld_q, out_vld_d;
  dtl_result_t out_q, out_d;
  logic        pend_q, pend_d;
  token_kind_e pend_kind_q, pend_kind_d;
  error_code_e pend_code_q, pend_code_d;
  logic        load;
  dtl_result_t end_res;

  assign load = !out_vld_q || out_o.ready;

  always_comb begin
    end_res             = '0;
    end_res.token_kind  = pend_kind_q;
    end_res.error_code  = pend_code_q;
    end_res.last_of_run = 1'b1;

    out_vld_d   = out_vld_q;
    out_d       = out_q;
    pend_d      = pend_q;
    pend_kind_d = pend_kind_q;
    pend_code_d = pend_code_q;
    pop_o       = 1'b0;

    if (load) begin
      if (pend_q) begin
        out_vld_d = 1'b1;
        out_d     = end_res;
        pend_d    = 1'b0;
      end else if (!q_stat_i.empty) begin
        pop_o     = 1'b1;
        out_vld_d = 1'b1;
        if (head_i.has_tok) begin
          out_d       = head_i.tok;
          pend_d      = head_i.has_end;
          pend_kind_d = head_i.end_kind;
          pend_code_d = head_i.end_code;
        end else begin
          out_d             = '0;
          out_d.token_kind  = head_i.end_kind;
          out_d.error_code  = head_i.end_code;
          out_d.last_of_run = 1'b1;
        end
      end else begin
        out_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q       <= out_d;
    pend_kind_q <= pend_kind_d;
    pend_code_q <= pend_code_d;
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.token_kind   = out_q.token_kind;
  assign out_o.error_code   = out_q.error_code;
  assign out_o.number_value = out_q.number_value;
  assign out_o.ident_text   = out_q.ident_text;
  assign out_o.ident_length = out_q.ident_length;
  assign out_o.last_of_run  = out_q.last_of_run;

endmodule

>>> rtl/delimited_token_lexer_top.sv
// Delimited token lexer, top level.
// Input channel in_i carries one text byte per beat; byte 0 ends the text.
// Output channel out_o carries token beats: kind, error code, number value,
// identifier text and length, and last_of_run on the final beat of a byte.
// A byte is taken every cycle while the result queue has room; the front end
// updates the lexeme (one constant multiply-add) in the cycle of acceptance.
// A delimiter, bad byte or end byte writes its entry into the queue at the
// accepting edge; the output register loads it from the queue once that register
// is free and no end beat is pending. An end byte that flushes a
// pending lexeme gives two beats, the token and then the end beat; the output
// side carries one beat per cycle while the receiver is ready.
// Reset clears the lexeme, the error hold, the queue count and the output valid flag;
// no beat is presented until a byte causes one.
// When the receiver stalls, the output beat holds and the queue fills; once
// it holds QueueDepth entries in_i.ready drops until the back end takes an entry.
// Depends on dtl_pkg, dtl_if, dtl_front, dtl_queue and dtl_back.
module delimited_token_lexer_top #(
  parameter int unsigned MaxIdentChars = dtl_pkg::MaxIdentCharsDefault,
  parameter int unsigned QueueDepth    = dtl_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dtl_byte_if.sink    in_i,
  dtl_token_if.source out_o
);
  import dtl_pkg::*;

  logic        push;
  dtl_entry_t  push_entry;
  logic        pop;
  dtl_entry_t  head;
  dtl_q_stat_t q_stat;

  dtl_front #(
    .MaxIdentChars(MaxIdentChars)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_entry_o(push_entry)
  );

  dtl_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  dtl_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .q_stat_i(q_stat),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

>>> tb/dtl_lexer_checker.sv
// token checker for the delimited token lexer: tracks the lexeme state from the
// accepted text bytes, queues the tokens they cause and compares every token beat
// depends on dtl_pkg and the channel interfaces in dtl_if
module dtl_lexer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  dtl_byte_if         text_i,
  dtl_token_if        token_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import dtl_pkg::*;

  localparam int unsigned MaxIdent = MaxIdentCharsDefault;

  logic [3:0]  lex_len;
  logic        digits_only;
  logic        ident_ok;
  logic [7:0]  lead_char;
  logic [31:0] acc_value;
  logic [63:0] ident_buf;
  logic        emitted_any;
  logic        holding;

  dtl_result_t expected_tokens[$];

  task automatic clear_lexeme();
    lex_len     = '0;
    digits_only = 1'b1;
    ident_ok    = 1'b1;
    lead_char   = '0;
    acc_value   = '0;
    ident_buf   = '0;
  endtask

  task automatic classify_lexeme(input logic last);
    dtl_result_t r;
    r = '0;
    r.last_of_run = last;
    if (digits_only) begin
      r.token_kind = KindNumber;
      r.number_value = acc_value;
      emitted_any = 1'b1;
    end else if (ident_ok) begin
      emitted_any = 1'b1;
      if (lex_len > MaxIdent) begin
        r.token_kind = KindIdent;
        r.error_code = ErrTooLong;
        r.ident_text = ident_buf;
        r.ident_length = 4'(MaxIdent);
      end else if (lex_len == 4'd4 && ident_buf == EchoWord) begin
        r.token_kind = KindEcho;
      end else begin
        r.token_kind = KindIdent;
        r.ident_text = ident_buf;
        r.ident_length = lex_len;
      end
    end else if (lex_len == 4'd1 && lead_char == CharPlus) begin
      r.token_kind = KindPlus;
      emitted_any = 1'b1;
    end else if (lex_len == 4'd1 && lead_char == CharEq) begin
      r.token_kind = KindEquals;
      emitted_any = 1'b1;
    end else begin
      r.token_kind = KindError;
      r.error_code = ErrMalformed;
      holding = 1'b1;
    end
    expected_tokens.push_back(r);
    clear_lexeme();
  endtask

  task automatic lex_byte(input logic [7:0] b);
    dtl_result_t r;
    logic dig;
    logic alp;
    dig = (b >= CharZero && b <= CharNine);
    alp = (b >= CharLoA && b <= CharLoZ) || (b >= CharUpA && b <= CharUpZ) ||
          b == CharUnder;
    r = '0;
    r.last_of_run = 1'b1;
    if (b == CharNul) begin
      if (!holding && lex_len != 0) classify_lexeme(1'b0);
      if (emitted_any) begin
        r.token_kind = KindEndOk;
      end else begin
        r.token_kind = KindError;
        r.error_code = ErrNoTokens;
      end
      expected_tokens.push_back(r);
      clear_lexeme();
      emitted_any = 1'b0;
      holding = 1'b0;
    end else if (!holding) begin
      if (b == CharSpace || b == CharNl) begin
        if (lex_len != 0) classify_lexeme(1'b1);
      end else if (!dig && !alp && b != CharPlus && b != CharEq) begin
        r.token_kind = KindError;
        r.error_code = ErrBadChar;
        expected_tokens.push_back(r);
        clear_lexeme();
        holding = 1'b1;
      end else begin
        if (lex_len == 0) begin
          lead_char = b;
          ident_ok = alp;
        end else begin
          ident_ok = ident_ok && (alp || dig);
        end
        digits_only = digits_only && dig;
        if (dig) acc_value = acc_value * 32'(Radix) + 32'(b - CharZero);
        if (lex_len < MaxIdent) ident_buf[int'(lex_len) * 8 +: 8] = b;
        if (lex_len != 4'd15) lex_len = lex_len + 4'd1;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count_o++;
    end
  endtask

  task automatic check_beat();
    dtl_result_t want;
    if (expected_tokens.size() == 0) begin
      $display("%0t: token beat with none expected, actual kind %0d code %0d",
               $time, token_i.token_kind, token_i.error_code);
      mismatch_count_o++;
    end else begin
      want = expected_tokens.pop_front();
      check_field("token_kind", 64'(want.token_kind), 64'(token_i.token_kind));
      check_field("error_code", 64'(want.error_code), 64'(token_i.error_code));
      check_field("number_value", 64'(want.number_value), 64'(token_i.number_value));
      check_field("ident_text", want.ident_text, token_i.ident_text);
      check_field("ident_length", 64'(want.ident_length), 64'(token_i.ident_length));
      check_field("last_of_run", 64'(want.last_of_run), 64'(token_i.last_of_run));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_lexeme();
      emitted_any = 1'b0;
      holding = 1'b0;
      expected_tokens.delete();
      mismatch_count_o = 0;
      pending_o <= 0;
    end else begin
      if (token_i.valid && token_i.ready) check_beat();
      if (text_i.valid && text_i.ready) lex_byte(text_i.text_byte);
      pending_o <= expected_tokens.size();
    end
  end

endmodule

>>> tb/delimited_token_lexer_top_tb.sv
// testbench top for delimited_token_lexer_top: clock, reset, text byte stimulus,
// token receiver with random and long stalls, watchdog and verdict
// depends on dtl_pkg, dtl_if, the lexer rtl and dtl_lexer_checker
module delimited_token_lexer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dtl_pkg::*;

  localparam int unsigned ClkHalf       = 5;
  localparam int unsigned RandomItems   = 550;
  localparam int unsigned HoldStart     = 200;
  localparam int unsigned HoldLen       = 250;
  localparam int unsigned QuietFrom     = 350;
  localparam int unsigned QuietTo       = 450;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned WatchdogLimit = 1000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          no_gaps;
  int unsigned bytes_sent;
  int unsigned stall_cycles = 0;
  int unsigned mismatches;
  int unsigned pending;

  dtl_byte_if  text_if ();
  dtl_token_if token_if ();

  delimited_token_lexer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (text_if),
    .out_o  (token_if)
  );

  dtl_lexer_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .text_i           (text_if),
    .token_i          (token_if),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  function automatic bit is_stray(input logic [7:0] c);
    return !((c >= CharZero && c <= CharNine) || (c >= CharLoA && c <= CharLoZ) ||
             (c >= CharUpA && c <= CharUpZ) ||
             c inside {CharUnder, CharPlus, CharEq, CharSpace, CharNl, CharNul});
  endfunction

  function automatic logic [7:0] stray_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (!is_stray(c));
    return c;
  endfunction

  function automatic logic [7:0] ident_char(input bit lead);
    int unsigned r;
    r = $urandom_range(lead ? 52 : 62);
    if (r < 26) return 8'(CharLoA + r);
    if (r < 52) return 8'(CharUpA + r - 26);
    if (r == 52) return CharUnder;
    return 8'(CharZero + r - 53);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit counted);
    while (!no_gaps && $urandom_range(99) < 19) begin
      text_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    text_if.valid <= 1'b1;
    text_if.text_byte <= b;
    @(posedge clk_i);
    while (!text_if.ready) @(posedge clk_i);
    if (counted) bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b1);
  endtask

  // one lexeme of random class; flags a lexeme that puts the lexer on error hold
  task automatic send_lexeme(output bit failed);
    int unsigned pick;
    int unsigned len;
    logic [7:0]  c;
    failed = 1'b0;
    pick = $urandom_range(99);
    if (pick < 28) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
      repeat (len) send_byte(8'(CharZero + $urandom_range(9)), 1'b1);
    end else if (pick < 58) begin
      len = ($urandom_range(5) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 8);
      send_byte(ident_char(1'b1), 1'b1);
      repeat (len - 1) send_byte(ident_char(1'b0), 1'b1);
    end else if (pick < 64) begin
      send_text("echo");
    end else if (pick < 74) begin
      send_byte(CharPlus, 1'b1);
    end else if (pick < 84) begin
      send_byte(CharEq, 1'b1);
    end else if (pick < 91) begin
      case ($urandom_range(2))
        0: begin
          send_byte(8'(CharZero + $urandom_range(9)), 1'b1);
          send_byte(ident_char(1'b1), 1'b1);
        end
        1: begin
          send_byte($urandom_range(1) ? CharPlus : CharEq, 1'b1);
          send_byte(ident_char(1'($urandom_range(1))), 1'b1);
        end
        default: begin
          send_byte(ident_char(1'b1), 1'b1);
          send_byte($urandom_range(1) ? CharPlus : CharEq, 1'b1);
        end
      endcase
      failed = 1'b1;
    end else if (pick < 95) begin
      if ($urandom_range(1)) send_byte(ident_char(1'b1), 1'b1);
      send_byte(stray_char(), 1'b1);
      failed = 1'b1;
    end else begin
      c = 8'($urandom_range(255));
      send_byte(c, 1'b1);
      failed = is_stray(c);
    end
  endtask

  initial begin : receiver
    int unsigned cyc;
    cyc = 0;
    token_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc >= HoldStart && cyc < HoldStart + HoldLen) token_if.ready <= 1'b0;
      else if (no_gaps) token_if.ready <= 1'b1;
      else token_if.ready <= ($urandom_range(99) >= 19);
    end
  end

  always @(posedge clk_i) begin
    if ((text_if.valid && text_if.ready) || (token_if.valid && token_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("delimited_token_lexer_top_tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    bit failed;
    int unsigned pick;
    rst_ni <= 1'b0;
    text_if.valid <= 1'b0;
    text_if.text_byte <= '0;
    no_gaps <= 1'b0;
    bytes_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bad byte with top bit set, then an end byte that finds no tokens
    send_byte(8'hFF, 1'b1);
    send_byte(CharNul, 1'b1);
    // long identifier, symbols, repeated delimiters, number, echo flushed by the end byte
    send_text("echo_abc9\n+ = 90  echo");
    send_byte(CharNul, 1'b1);
    // malformed lexeme, then a pending lexeme dropped under error hold
    send_text("0a 9");
    send_byte(CharNul, 1'b1);

    bytes_sent = 0;
    while (bytes_sent < RandomItems) begin
      no_gaps <= (bytes_sent >= QuietFrom && bytes_sent < QuietTo);
      send_lexeme(failed);
      if (failed) begin
        repeat ($urandom_range(3)) send_byte(8'($urandom_range(1, 255)), 1'b0);
        send_byte(CharNul, 1'b1);
      end else begin
        pick = $urandom_range(9);
        if (pick != 0)
          repeat ($urandom_range(1, 3)) send_byte($urandom_range(1) ? CharSpace : CharNl, 1'b1);
        if (pick < 2) send_byte(CharNul, 1'b1);
      end
    end
    send_byte(CharNul, 1'b1);
    text_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("delimited_token_lexer_top_tb passed");
    end else begin
      $display("delimited_token_lexer_top_tb failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/dtl_pkg.sv
rtl/dtl_if.sv
rtl/dtl_front.sv
rtl/dtl_queue.sv
rtl/dtl_back.sv
rtl/delimited_token_lexer_top.sv
tb/dtl_lexer_checker.sv
tb/delimited_token_lexer_top_tb.sv
